// ----- hw/rtl/assert_macros.svh -----
// Assertion helpers for the RTL, included by hmac_sha256_sign_verify.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTHESIS
`define CHK_ASSERT(name, prop, msg) \
    name: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);
`define CHK_NEVER(name, expr, msg) \
    name: assert property (@(posedge clk) disable iff (!rst_n) !(expr)) else $error(msg);
`else
`define CHK_ASSERT(name, prop, msg)
`define CHK_NEVER(name, expr, msg)
`endif
`endif

// ----- hw/rtl/hs_pkg.sv -----
// ----------------------------------------------------------------------------
// hs_pkg
// Types, constants and round functions for the HMAC-SHA256 block.
// ----------------------------------------------------------------------------
package hs_pkg;

    localparam int KEY_BYTES   = 32;
    localparam int KEY_WORDS32 = KEY_BYTES / 4;

    localparam logic [31:0] IPAD_WORD = 32'h36363636;
    localparam logic [31:0] OPAD_WORD = 32'h5c5c5c5c;
    localparam logic [31:0] PAD_MARK  = 32'h80000000;
    // 64-byte key block plus 32-byte inner digest = 768 bits
    localparam logic [31:0] OUTER_LEN = 32'h00000300;
    localparam logic [7:0]  PAD_BYTE  = 8'h80;

    localparam logic [255:0] IV = {
        32'h5be0cd19, 32'h1f83d9ab, 32'h9b05688c, 32'h510e527f,
        32'ha54ff53a, 32'h3c6ef372, 32'hbb67ae85, 32'h6a09e667
    };

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_FILL,
        ST_ABSORB,
        ST_PAD,
        ST_KICK,
        ST_WAIT,
        ST_MATCH,
        ST_OUT
    } state_t;

    // what follows a compression
    typedef enum logic [2:0] {
        CONT_KEY_IN,
        CONT_DATA,
        CONT_PAD,
        CONT_KEY_OUT,
        CONT_OUTER
    } cont_t;

    typedef enum logic [1:0] {
        FILL_KEY_IN,
        FILL_KEY_OUT,
        FILL_OUTER
    } fill_t;

    typedef struct packed {
        logic        init;
        logic        push;
        logic        start;
        logic [31:0] word;
    } core_cmd_t;

    function automatic logic [31:0] rotr(input logic [31:0] x, input int n);
        return (x >> n) | (x << (32 - n));
    endfunction

    function automatic logic [31:0] round_k(input logic [5:0] i);
        logic [31:0] k;
        case (i)
            6'd0:  k = 32'h428a2f98; 6'd1:  k = 32'h71374491;
            6'd2:  k = 32'hb5c0fbcf; 6'd3:  k = 32'he9b5dba5;
            6'd4:  k = 32'h3956c25b; 6'd5:  k = 32'h59f111f1;
            6'd6:  k = 32'h923f82a4; 6'd7:  k = 32'hab1c5ed5;
            6'd8:  k = 32'hd807aa98; 6'd9:  k = 32'h12835b01;
            6'd10: k = 32'h243185be; 6'd11: k = 32'h550c7dc3;
            6'd12: k = 32'h72be5d74; 6'd13: k = 32'h80deb1fe;
            6'd14: k = 32'h9bdc06a7; 6'd15: k = 32'hc19bf174;
            6'd16: k = 32'he49b69c1; 6'd17: k = 32'hefbe4786;
            6'd18: k = 32'h0fc19dc6; 6'd19: k = 32'h240ca1cc;
            6'd20: k = 32'h2de92c6f; 6'd21: k = 32'h4a7484aa;
            6'd22: k = 32'h5cb0a9dc; 6'd23: k = 32'h76f988da;
            6'd24: k = 32'h983e5152; 6'd25: k = 32'ha831c66d;
            6'd26: k = 32'hb00327c8; 6'd27: k = 32'hbf597fc7;
            6'd28: k = 32'hc6e00bf3; 6'd29: k = 32'hd5a79147;
            6'd30: k = 32'h06ca6351; 6'd31: k = 32'h14292967;
            6'd32: k = 32'h27b70a85; 6'd33: k = 32'h2e1b2138;
            6'd34: k = 32'h4d2c6dfc; 6'd35: k = 32'h53380d13;
            6'd36: k = 32'h650a7354; 6'd37: k = 32'h766a0abb;
            6'd38: k = 32'h81c2c92e; 6'd39: k = 32'h92722c85;
            6'd40: k = 32'ha2bfe8a1; 6'd41: k = 32'ha81a664b;
            6'd42: k = 32'hc24b8b70; 6'd43: k = 32'hc76c51a3;
            6'd44: k = 32'hd192e819; 6'd45: k = 32'hd6990624;
            6'd46: k = 32'hf40e3585; 6'd47: k = 32'h106aa070;
            6'd48: k = 32'h19a4c116; 6'd49: k = 32'h1e376c08;
            6'd50: k = 32'h2748774c; 6'd51: k = 32'h34b0bcb5;
            6'd52: k = 32'h391c0cb3; 6'd53: k = 32'h4ed8aa4a;
            6'd54: k = 32'h5b9cca4f; 6'd55: k = 32'h682e6ff3;
            6'd56: k = 32'h748f82ee; 6'd57: k = 32'h78a5636f;
            6'd58: k = 32'h84c87814; 6'd59: k = 32'h8cc70208;
            6'd60: k = 32'h90befffa; 6'd61: k = 32'ha4506ceb;
            6'd62: k = 32'hbef9a3f7; 6'd63: k = 32'hc67178f2;
            default: k = 32'h0;
        endcase
        return k;
    endfunction

endpackage

// ----- hw/rtl/hmac_sha256_sign_verify.sv -----
// ----------------------------------------------------------------------------
// hmac_sha256_sign_verify
// HMAC-SHA256 over a byte stream with a 32-byte key and MAC compare.
// ----------------------------------------------------------------------------
// Usage: write the key as four 64-bit words on cfg_we/cfg_addr/cfg_data while
// idle. Requests on the s_ group carry either a message byte (s_tuser = 0,
// s_tlast marks the final byte) or an expected MAC word (s_tuser = 1).
// A word is stored at once; an ordinary byte passes through the absorb state
// first. The first byte of a message also runs the inner key block, and each
// byte that completes a 64-byte block runs a compression, one SHA-256 round
// per cycle in the shared core. The final byte runs the padding (one byte per
// cycle, pausing at each block end, 9 to 72 bytes), its compressions and the
// outer key and digest blocks, then shows the MAC on m_ as four words, most
// significant first, with m_tuser the match flag on every word.
// s_tready is low from acceptance of a byte until it is handled, and while the
// MAC is shown; a stalled receiver simply holds the current word.
// Reset returns to idle with an empty message, no expected words and a zero key.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module hmac_sha256_sign_verify
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        cfg_we,
    input  logic [1:0]  cfg_addr,
    input  logic [63:0] cfg_data,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [71:0] s_tdata,  // msg_byte[7:0], expected_word[71:8]
    input  logic        s_tlast,
    input  logic        s_tuser,  // action
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [71:0] m_tdata,  // mac_word[63:0], word_index[65:64], zeros
    output logic        m_tlast,
    output logic        m_tuser   // match
);

    hs_pkg::state_t    state_reg, state_next;
    hs_pkg::cont_t     cont_reg, cont_next;
    hs_pkg::fill_t     mode_reg, mode_next;
    hs_pkg::core_cmd_t cmd;

    logic [3:0]   fill_reg, fill_next;
    logic [5:0]   pos_reg, pos_next;
    logic [63:0]  msg_reg, msg_next;
    logic [23:0]  acc_reg, acc_next;
    logic [7:0]   byte_reg, byte_next;
    logic         eom_reg, eom_next;
    logic         phase_reg, phase_next;
    logic         first_reg, first_next;
    logic         len_ok_reg, len_ok_next;
    logic [2:0]   loaded_reg, loaded_next;
    logic [255:0] inner_reg, inner_next;
    logic [1:0]   idx_reg, idx_next;
    logic         match_reg, match_next;
    logic [63:0]  key_reg [4];
    logic [63:0]  exp_reg [4];

    logic         core_done;
    logic [255:0] digest;
    logic [7:0]   bval;
    logic [63:0]  len_bits;
    logic [31:0]  fill_word;
    logic [63:0]  key_sel;
    logic [63:0]  mac_sel [4];
    logic         s_req, m_req;

    hs_core u_core
    (
        .clk    (clk),
        .rst_n  (rst_n),
        .cmd    (cmd),
        .done   (core_done),
        .digest (digest)
    );

    always_comb
    begin
        for (int i = 0; i < 4; i++)
        begin
            mac_sel[i] = {digest[64*i +: 32], digest[64*i + 32 +: 32]};
        end
    end

    assign s_req    = s_tvalid && s_tready;
    assign m_req    = m_tvalid && m_tready;
    assign s_tready = (state_reg == hs_pkg::ST_IDLE);
    assign m_tvalid = (state_reg == hs_pkg::ST_OUT);
    assign m_tdata  = {6'b0, idx_reg, mac_sel[idx_reg]};
    assign m_tlast  = (idx_reg == 2'd3);
    assign m_tuser  = match_reg;

    // bit length includes the 64-byte key block
    assign len_bits = {msg_reg[60:0] + 61'd64, 3'b000};
    assign key_sel  = key_reg[fill_reg[2:1]];

    always_comb
    begin
        if (state_reg == hs_pkg::ST_ABSORB)
        begin
            bval = byte_reg;
        end
        else if (first_reg)
        begin
            bval = hs_pkg::PAD_BYTE;
        end
        else if (len_ok_reg && pos_reg >= 6'd56)
        begin
            bval = len_bits[{~pos_reg[2:0], 3'b000} +: 8];
        end
        else
        begin
            bval = 8'h00;
        end

        case (mode_reg)
            hs_pkg::FILL_KEY_IN, hs_pkg::FILL_KEY_OUT:
            begin
                if (32'(fill_reg) < hs_pkg::KEY_WORDS32)
                begin
                    fill_word = fill_reg[0] ? key_sel[31:0] : key_sel[63:32];
                end
                else
                begin
                    fill_word = '0;
                end
                fill_word = fill_word ^ ((mode_reg == hs_pkg::FILL_KEY_IN) ?
                                         hs_pkg::IPAD_WORD : hs_pkg::OPAD_WORD);
            end
            hs_pkg::FILL_OUTER:
            begin
                // inner digest word 0 sits in the low bits
                if (fill_reg < 4'd8)
                begin
                    fill_word = inner_reg[31:0];
                end
                else if (fill_reg == 4'd8)
                begin
                    fill_word = hs_pkg::PAD_MARK;
                end
                else if (fill_reg == 4'd15)
                begin
                    fill_word = hs_pkg::OUTER_LEN;
                end
                else
                begin
                    fill_word = '0;
                end
            end
            default:
            begin
                fill_word = '0;
            end
        endcase
    end

    always_comb
    begin
        state_next  = state_reg;
        cont_next   = cont_reg;
        mode_next   = mode_reg;
        fill_next   = fill_reg;
        pos_next    = pos_reg;
        msg_next    = msg_reg;
        acc_next    = acc_reg;
        byte_next   = byte_reg;
        eom_next    = eom_reg;
        phase_next  = phase_reg;
        first_next  = first_reg;
        len_ok_next = len_ok_reg;
        loaded_next = loaded_reg;
        inner_next  = inner_reg;
        idx_next    = idx_reg;
        match_next  = match_reg;
        cmd         = '0;

        case (state_reg)
            hs_pkg::ST_IDLE:
            begin
                if (s_req && !s_tuser)
                begin
                    byte_next = s_tdata[7:0];
                    eom_next  = s_tlast;
                    if (!phase_reg)
                    begin
                        cmd.init   = 1'b1;
                        msg_next   = '0;
                        pos_next   = '0;
                        phase_next = 1'b1;
                        mode_next  = hs_pkg::FILL_KEY_IN;
                        fill_next  = '0;
                        state_next = hs_pkg::ST_FILL;
                    end
                    else
                    begin
                        state_next = hs_pkg::ST_ABSORB;
                    end
                end
                else if (s_req && loaded_reg < 3'd4)
                begin
                    loaded_next = loaded_reg + 3'd1;
                end
            end
            hs_pkg::ST_FILL:
            begin
                cmd.push  = 1'b1;
                cmd.word  = fill_word;
                fill_next = fill_reg + 4'd1;
                if (mode_reg == hs_pkg::FILL_OUTER)
                begin
                    inner_next = {32'h0, inner_reg[255:32]};
                end
                if (fill_reg == 4'd15)
                begin
                    state_next = hs_pkg::ST_KICK;
                    case (mode_reg)
                        hs_pkg::FILL_KEY_IN:  cont_next = hs_pkg::CONT_KEY_IN;
                        hs_pkg::FILL_KEY_OUT: cont_next = hs_pkg::CONT_KEY_OUT;
                        default:              cont_next = hs_pkg::CONT_OUTER;
                    endcase
                end
            end
            hs_pkg::ST_ABSORB, hs_pkg::ST_PAD:
            begin
                acc_next = {acc_reg[15:0], bval};
                pos_next = pos_reg + 6'd1;
                if (pos_reg[1:0] == 2'd3)
                begin
                    cmd.push = 1'b1;
                    cmd.word = {acc_reg, bval};
                end
                if (state_reg == hs_pkg::ST_ABSORB)
                begin
                    msg_next = msg_reg + 64'd1;
                end
                else if (first_reg)
                begin
                    first_next  = 1'b0;
                    len_ok_next = (pos_reg < 6'd56);
                end
                if (pos_reg == 6'd63)
                begin
                    state_next = hs_pkg::ST_KICK;
                    cont_next  = (state_reg == hs_pkg::ST_ABSORB) ?
                                 hs_pkg::CONT_DATA : hs_pkg::CONT_PAD;
                end
                else if (state_reg == hs_pkg::ST_ABSORB)
                begin
                    if (eom_reg)
                    begin
                        first_next = 1'b1;
                        state_next = hs_pkg::ST_PAD;
                    end
                    else
                    begin
                        state_next = hs_pkg::ST_IDLE;
                    end
                end
            end
            hs_pkg::ST_KICK:
            begin
                cmd.start  = 1'b1;
                state_next = hs_pkg::ST_WAIT;
            end
            hs_pkg::ST_WAIT:
            begin
                if (core_done)
                begin
                    case (cont_reg)
                        hs_pkg::CONT_KEY_IN:
                        begin
                            state_next = hs_pkg::ST_ABSORB;
                        end
                        hs_pkg::CONT_DATA:
                        begin
                            if (eom_reg)
                            begin
                                first_next = 1'b1;
                                state_next = hs_pkg::ST_PAD;
                            end
                            else
                            begin
                                state_next = hs_pkg::ST_IDLE;
                            end
                        end
                        hs_pkg::CONT_PAD:
                        begin
                            if (len_ok_reg)
                            begin
                                // inner hash finished: start outer pass
                                inner_next = digest;
                                cmd.init   = 1'b1;
                                mode_next  = hs_pkg::FILL_KEY_OUT;
                                fill_next  = '0;
                                state_next = hs_pkg::ST_FILL;
                            end
                            else
                            begin
                                len_ok_next = 1'b1;
                                state_next  = hs_pkg::ST_PAD;
                            end
                        end
                        hs_pkg::CONT_KEY_OUT:
                        begin
                            mode_next  = hs_pkg::FILL_OUTER;
                            fill_next  = '0;
                            state_next = hs_pkg::ST_FILL;
                        end
                        default:
                        begin
                            state_next = hs_pkg::ST_MATCH;
                        end
                    endcase
                end
            end
            hs_pkg::ST_MATCH:
            begin
                match_next  = (loaded_reg == 3'd4) && (exp_reg[0] == mac_sel[0])
                           && (exp_reg[1] == mac_sel[1]) && (exp_reg[2] == mac_sel[2])
                           && (exp_reg[3] == mac_sel[3]);
                loaded_next = '0;
                msg_next    = '0;
                phase_next  = 1'b0;
                idx_next    = '0;
                state_next  = hs_pkg::ST_OUT;
            end
            hs_pkg::ST_OUT:
            begin
                if (m_req)
                begin
                    idx_next = idx_reg + 2'd1;
                    if (idx_reg == 2'd3)
                    begin
                        state_next = hs_pkg::ST_IDLE;
                    end
                end
            end
            default:
            begin
                state_next = hs_pkg::ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg  <= hs_pkg::ST_IDLE;
            cont_reg   <= hs_pkg::CONT_KEY_IN;
            mode_reg   <= hs_pkg::FILL_KEY_IN;
            fill_reg   <= '0;
            pos_reg    <= '0;
            msg_reg    <= '0;
            eom_reg    <= 1'b0;
            phase_reg  <= 1'b0;
            first_reg  <= 1'b0;
            len_ok_reg <= 1'b0;
            loaded_reg <= '0;
            idx_reg    <= '0;
            match_reg  <= 1'b0;
            for (int i = 0; i < 4; i++)
            begin
                key_reg[i] <= '0;
            end
        end
        else
        begin
            state_reg  <= state_next;
            cont_reg   <= cont_next;
            mode_reg   <= mode_next;
            fill_reg   <= fill_next;
            pos_reg    <= pos_next;
            msg_reg    <= msg_next;
            eom_reg    <= eom_next;
            phase_reg  <= phase_next;
            first_reg  <= first_next;
            len_ok_reg <= len_ok_next;
            loaded_reg <= loaded_next;
            idx_reg    <= idx_next;
            match_reg  <= match_next;
            if (cfg_we)
            begin
                key_reg[cfg_addr] <= cfg_data;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        acc_reg   <= acc_next;
        byte_reg  <= byte_next;
        inner_reg <= inner_next;
        if (s_req && s_tuser && loaded_reg < 3'd4)
        begin
            exp_reg[loaded_reg[1:0]] <= s_tdata[71:8];
        end
    end

    `CHK_NEVER(a_in_out_excl, s_tready && m_tvalid, "request taken while MAC shown")
    `CHK_ASSERT(a_done_in_wait, core_done |-> state_reg == hs_pkg::ST_WAIT, "core done outside wait")
    `CHK_NEVER(a_loaded_max, loaded_reg > 3'd4, "expected word count overflow")
    `CHK_ASSERT(a_out_clears, (m_req && m_tlast) |=> (loaded_reg == 3'd0 && !phase_reg), "state not cleared after MAC")

endmodule

// ----- hw/rtl/hs_core.sv -----
// ----------------------------------------------------------------------------
// hs_core
// SHA-256 compression, one round per cycle, with a 16-word schedule window.
// ----------------------------------------------------------------------------
module hs_core
(
    input  logic              clk,
    input  logic              rst_n,
    input  hs_pkg::core_cmd_t cmd,
    output logic              done,
    output logic [255:0]      digest
);

    logic [7:0][31:0]  h_reg, h_next;
    logic [7:0][31:0]  v_reg, v_next;
    logic [15:0][31:0] w_reg, w_next;
    logic [5:0]        cnt_reg, cnt_next;
    logic              run_reg, run_next;
    logic              fold_reg, fold_next;
    logic              done_reg, done_next;

    logic [31:0] big_s0, big_s1, ch, mj, t1, t2, sig0, sig1, w_new;

    always_comb
    begin
        big_s1 = hs_pkg::rotr(v_reg[4], 6) ^ hs_pkg::rotr(v_reg[4], 11)
               ^ hs_pkg::rotr(v_reg[4], 25);
        ch     = (v_reg[4] & v_reg[5]) ^ (~v_reg[4] & v_reg[6]);
        t1     = v_reg[7] + big_s1 + ch + hs_pkg::round_k(cnt_reg) + w_reg[0];
        big_s0 = hs_pkg::rotr(v_reg[0], 2) ^ hs_pkg::rotr(v_reg[0], 13)
               ^ hs_pkg::rotr(v_reg[0], 22);
        mj     = (v_reg[0] & v_reg[1]) ^ (v_reg[0] & v_reg[2]) ^ (v_reg[1] & v_reg[2]);
        t2     = big_s0 + mj;
        sig0   = hs_pkg::rotr(w_reg[1], 7) ^ hs_pkg::rotr(w_reg[1], 18) ^ (w_reg[1] >> 3);
        sig1   = hs_pkg::rotr(w_reg[14], 17) ^ hs_pkg::rotr(w_reg[14], 19)
               ^ (w_reg[14] >> 10);
        w_new  = w_reg[0] + sig0 + w_reg[9] + sig1;

        h_next    = h_reg;
        v_next    = v_reg;
        w_next    = w_reg;
        cnt_next  = cnt_reg;
        run_next  = run_reg;
        fold_next = 1'b0;
        // done follows the fold, so digest is final while done is high
        done_next = fold_reg;

        if (cmd.init)
        begin
            h_next = hs_pkg::IV;
        end
        if (cmd.push)
        begin
            w_next = {cmd.word, w_reg[15:1]};
        end
        if (cmd.start)
        begin
            v_next   = h_reg;
            cnt_next = '0;
            run_next = 1'b1;
        end
        if (run_reg)
        begin
            v_next   = {v_reg[6], v_reg[5], v_reg[4], v_reg[3] + t1,
                        v_reg[2], v_reg[1], v_reg[0], t1 + t2};
            w_next   = {w_new, w_reg[15:1]};
            cnt_next = cnt_reg + 6'd1;
            if (cnt_reg == 6'd63)
            begin
                run_next  = 1'b0;
                fold_next = 1'b1;
            end
        end
        if (fold_reg)
        begin
            for (int i = 0; i < 8; i++)
            begin
                h_next[i] = h_reg[i] + v_reg[i];
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            h_reg    <= hs_pkg::IV;
            cnt_reg  <= '0;
            run_reg  <= 1'b0;
            fold_reg <= 1'b0;
            done_reg <= 1'b0;
        end
        else
        begin
            h_reg    <= h_next;
            cnt_reg  <= cnt_next;
            run_reg  <= run_next;
            fold_reg <= fold_next;
            done_reg <= done_next;
        end
    end

    always_ff @(posedge clk)
    begin
        v_reg <= v_next;
        w_reg <= w_next;
    end

    assign done   = done_reg;
    assign digest = h_reg;

endmodule
